@@ hdl/ccq_pkg.sv @@
`timescale 1ns / 1ps

package ccq_pkg;

    // Command word opcode and result status encodings.
    typedef logic [1:0] t_cmd;
    typedef logic [2:0] t_status;

    localparam t_cmd CMD_ENQ      = 2'd0;
    localparam t_cmd CMD_DEQ_HEAD = 2'd1;
    localparam t_cmd CMD_DEQ_KEY  = 2'd2;
    localparam t_cmd CMD_QUERY    = 2'd3;

    localparam t_status ST_APPENDED = 3'd0;
    localparam t_status ST_REPLACED = 3'd1;
    localparam t_status ST_DROPPED  = 3'd2;
    localparam t_status ST_REMOVED  = 3'd3;
    localparam t_status ST_MISS     = 3'd4;
    localparam t_status ST_HIT      = 3'd5;

endpackage

@@ hdl/ccq_ram.sv @@
`timescale 1ns / 1ps

module ccq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/coalescing_command_queue.sv @@
`timescale 1ns / 1ps
// Sequence: a head dequeue reads the head entry, takes it in the compare state, then passes the
// done state (from idle straight to done when empty); a keyed command reads and compares each
// entry in turn, moves each later entry down by a read and a write after a keyed removal, then waits in done.
// Throughput: one command at a time; a finished command waits while the last word is held.
// Reset: i_rst_n is synchronous and active low; it empties the queue and drops any pending result.
// The entry RAM is not cleared; only entries below the count are ever read.

module coalescing_command_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BITS    = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ccq_pkg::t_cmd    i_cmd,
    input  logic [31:0]      i_key,
    input  logic [31:0]      i_handle_in,
    output logic             o_valid,
    input  logic             i_ready,
    output ccq_pkg::t_status o_status,
    output logic [31:0]      o_handle_out,
    output logic [31:0]      o_key_out,
    output logic [4:0]       o_occupancy
);

    import ccq_pkg::*;

    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = KW + 32;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_SH_RD = 3'd3;
    localparam logic [2:0] S_SH_WR = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]    r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [KW-1:0] r_key, n_key;
    logic [31:0]   r_hin, n_hin;
    logic [CW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    t_status       r_res_status, n_res_status;
    logic [31:0]   r_res_handle, n_res_handle;
    logic [KW-1:0] r_res_key, n_res_key;
    logic          r_out_valid, n_out_valid;
    t_status       r_out_status, n_out_status;
    logic [31:0]   r_out_handle, n_out_handle;
    logic [KW-1:0] r_out_key, n_out_key;
    logic [CW-1:0] r_out_occ, n_out_occ;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;
    logic [DW-1:0] w_rdata;
    logic [KW-1:0] w_rd_key;
    logic [31:0]   w_rd_handle;
    logic [CW:0]   w_pos_next;

    logic [CW+4:0] w_occ_ext;
    logic [KW+31:0] w_key_ext;

    // Physical RAM address of a queue position, counted from the head.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] pos);
        logic [CW:0] s;
        s = {{(CW+1-AW){1'b0}}, head} + {1'b0, pos};
        if (s >= (CW+1)'(QUEUE_DEPTH)) begin
            s = s - (CW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    ccq_ram #(
        .WIDTH (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_key    = w_rdata[DW-1:32];
    assign w_rd_handle = w_rdata[31:0];
    assign w_pos_next  = {1'b0, r_pos} + (CW+1)'(1);

    // Command sequencer: read the head or walk the queue, then update entries and count.
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_hin        = r_hin;
        n_pos        = r_pos;
        n_head       = r_head;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        n_res_key    = r_res_key;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_handle = r_out_handle;
        n_out_key    = r_out_key;
        n_out_occ    = r_out_occ;
        w_we         = 1'b0;
        w_waddr      = phys(r_head, r_pos);
        w_wdata      = {r_key, r_hin};
        w_raddr      = phys(r_head, r_pos);

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd        = i_cmd;
                    n_key        = i_key[KW-1:0];
                    n_hin        = i_handle_in;
                    n_pos        = '0;
                    n_res_handle = '0;
                    n_res_key    = '0;
                    if (i_cmd == CMD_DEQ_HEAD) begin
                        if (r_count == '0) begin
                            n_res_status = ST_MISS;
                            n_state      = S_DONE;
                        end else begin
                            w_raddr = r_head;
                            n_state = S_CMP;
                        end
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_pos == r_count) begin
                    // No entry holds the key.
                    n_state = S_DONE;
                    if (r_cmd == CMD_ENQ) begin
                        if (r_count < CW'(QUEUE_DEPTH)) begin
                            w_we         = 1'b1;
                            w_waddr      = phys(r_head, r_count);
                            n_count      = r_count + CW'(1);
                            n_res_status = ST_APPENDED;
                        end else begin
                            n_res_status = ST_DROPPED;
                        end
                    end else begin
                        n_res_status = ST_MISS;
                    end
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_cmd == CMD_DEQ_HEAD) begin
                    n_res_handle = w_rd_handle;
                    n_res_key    = w_rd_key;
                    n_res_status = ST_REMOVED;
                    n_head       = phys(r_head, CW'(1));
                    n_count      = r_count - CW'(1);
                    n_state      = S_DONE;
                end else if (w_rd_key == r_key) begin
                    case (r_cmd)
                        CMD_ENQ: begin
                            w_we         = 1'b1;
                            n_res_status = ST_REPLACED;
                            n_state      = S_DONE;
                        end
                        CMD_DEQ_KEY: begin
                            n_res_handle = w_rd_handle;
                            n_res_key    = w_rd_key;
                            n_res_status = ST_REMOVED;
                            n_state      = S_SH_RD;
                        end
                        default: begin
                            n_res_status = ST_HIT;
                            n_state      = S_DONE;
                        end
                    endcase
                end else begin
                    n_pos   = w_pos_next[CW-1:0];
                    n_state = S_RD;
                end
            end
            S_SH_RD: begin
                // Pull the following entry down by one place to close the gap.
                if (w_pos_next < {1'b0, r_count}) begin
                    w_raddr = phys(r_head, w_pos_next[CW-1:0]);
                    n_state = S_SH_WR;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_SH_WR: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
                n_pos   = w_pos_next[CW-1:0];
                n_state = S_SH_RD;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_handle = r_res_handle;
                    n_out_key    = r_res_key;
                    n_out_occ    = r_count;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state is reset; payload registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_hin        <= n_hin;
        r_pos        <= n_pos;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_res_key    <= n_res_key;
        r_out_status <= n_out_status;
        r_out_handle <= n_out_handle;
        r_out_key    <= n_out_key;
        r_out_occ    <= n_out_occ;
    end

    // Result word ports.
    assign w_occ_ext = {5'b0, r_out_occ};
    assign w_key_ext = {32'b0, r_out_key};

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_handle_out = r_out_handle;
    assign o_key_out    = w_key_ext[31:0];
    assign o_occupancy  = w_occ_ext[4:0];

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import ccq_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int KEY_POOL_SIZE  = 24;
    localparam int RANDOM_CMDS    = 500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        t_cmd        op;
        logic [31:0] key;
        logic [31:0] handle;
    } t_cmd_word;

    typedef struct {
        t_status     status;
        logic [31:0] handle;
        logic [31:0] key;
        logic [4:0]  occupancy;
    } t_reply_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_cmd        i_cmd = CMD_QUERY;
    logic [31:0] i_key = '0;
    logic [31:0] i_handle_in = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_status     o_status;
    logic [31:0] o_handle_out;
    logic [31:0] o_key_out;
    logic [4:0]  o_occupancy;

    // Commands waiting to be offered, and replies the queue still owes us.
    t_cmd_word   cmd_backlog[$];
    t_reply_word replies_due[$];
    logic [31:0] key_pool[KEY_POOL_SIZE];

    // Shadow copy of the queue contents, head at position 0.
    logic [31:0] held_keys[QUEUE_DEPTH];
    logic [31:0] held_handles[QUEUE_DEPTH];
    int          held_count = 0;

    int total_cmds = 0;
    int cmds_accepted = 0;
    int replies_seen = 0;
    int error_count = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit stall_done = 1'b0;

    coalescing_command_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .KEY_BITS   (32)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_key       (i_key),
        .i_handle_in (i_handle_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_handle_out(o_handle_out),
        .o_key_out   (o_key_out),
        .o_occupancy (o_occupancy)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Apply one command to the shadow queue and return the reply it should produce.
    function automatic t_reply_word apply_command(t_cmd op, logic [31:0] k, logic [31:0] h);
        t_reply_word r;
        int          pos;
        r.status = ST_MISS;
        r.handle = '0;
        r.key    = '0;
        pos = held_count;
        for (int j = held_count - 1; j >= 0; j--) begin
            if (held_keys[j] == k) begin
                pos = j;
            end
        end
        case (op)
            CMD_ENQ: begin
                if (pos < held_count) begin
                    held_handles[pos] = h;
                    r.status = ST_REPLACED;
                end else if (held_count < QUEUE_DEPTH) begin
                    held_keys[held_count]    = k;
                    held_handles[held_count] = h;
                    held_count++;
                    r.status = ST_APPENDED;
                end else begin
                    r.status = ST_DROPPED;
                end
            end
            CMD_DEQ_HEAD: begin
                if (held_count > 0) begin
                    pos = 0;
                    r.status = ST_REMOVED;
                end
            end
            CMD_DEQ_KEY: begin
                if (pos < held_count) begin
                    r.status = ST_REMOVED;
                end
            end
            default: begin
                r.status = (pos < held_count) ? ST_HIT : ST_MISS;
            end
        endcase
        // A removal hands back the entry and closes the gap behind it.
        if (r.status == ST_REMOVED) begin
            r.handle = held_handles[pos];
            r.key    = held_keys[pos];
            for (int j = pos; j + 1 < held_count; j++) begin
                held_keys[j]    = held_keys[j + 1];
                held_handles[j] = held_handles[j + 1];
            end
            held_count--;
        end
        r.occupancy = held_count[4:0];
        return r;
    endfunction

    task automatic add_cmd(t_cmd op, logic [31:0] k, logic [31:0] h);
        t_cmd_word c;
        c.op     = op;
        c.key    = k;
        c.handle = h;
        cmd_backlog.push_back(c);
    endtask

    // Pick a key: mostly from a small pool so that matches and a full queue are common.
    function automatic logic [31:0] pick_key();
        if ($urandom_range(99) < 80) begin
            return key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    // Driver: offers the next backlog word, holding it steady until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                cmds_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (cmd_backlog.size() > 0 &&
                    ((cmds_accepted >= 300 && cmds_accepted < 380) ||
                     $urandom_range(99) >= 28)) begin
                    i_cmd       <= cmd_backlog[0].op;
                    i_key       <= cmd_backlog[0].key;
                    i_handle_in <= cmd_backlog[0].handle;
                    i_valid     <= 1'b1;
                    void'(cmd_backlog.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off so the queue backs up, and a stall-free stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (!stall_done && replies_seen >= 150) begin
            stall_done = 1'b1;
            stall_left = 80;
            i_ready <= 1'b0;
        end else if (replies_seen >= 300 && replies_seen < 380) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 28);
        end
    end

    // Monitor: predict on each accepted command, check each accepted reply.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                replies_due.push_back(apply_command(i_cmd, i_key, i_handle_in));
            end
            if (o_valid && i_ready) begin
                replies_seen++;
                if (replies_due.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("unexpected reply: status %0d handle %h key %h occupancy %0d",
                                 o_status, o_handle_out, o_key_out, o_occupancy);
                    end
                end else begin
                    if (o_status !== replies_due[0].status ||
                        o_handle_out !== replies_due[0].handle ||
                        o_key_out !== replies_due[0].key ||
                        o_occupancy !== replies_due[0].occupancy) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("reply %0d mismatch: expected status %0d handle %h",
                                     replies_seen, replies_due[0].status,
                                     replies_due[0].handle);
                            $display("    expected key %h occ %0d", replies_due[0].key,
                                     replies_due[0].occupancy);
                            $display("    got status %0d handle %h key %h occ %0d",
                                     o_status, o_handle_out, o_key_out, o_occupancy);
                        end
                    end
                    void'(replies_due.pop_front());
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int   phase;
        int   pick;
        t_cmd op;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int j = 2; j < KEY_POOL_SIZE; j++) begin
            key_pool[j] = $urandom;
        end

        // Empty queue: every removal and lookup misses.
        add_cmd(CMD_DEQ_HEAD, 32'h0, 32'h0);
        add_cmd(CMD_DEQ_KEY, 32'h0, 32'hFFFF_FFFF);
        add_cmd(CMD_QUERY, 32'hFFFF_FFFF, 32'h0);
        // Extreme keys and handles, a replacement in place, then a hit, a miss and a missed removal.
        add_cmd(CMD_ENQ, 32'h0, 32'hFFFF_FFFF);
        add_cmd(CMD_ENQ, 32'hFFFF_FFFF, 32'h0);
        add_cmd(CMD_ENQ, 32'h0, 32'h1234_5678);
        add_cmd(CMD_QUERY, 32'hFFFF_FFFF, 32'h0);
        add_cmd(CMD_QUERY, 32'h5A5A_5A5A, 32'h0);
        add_cmd(CMD_DEQ_KEY, 32'h5A5A_5A5A, 32'h0);
        // Fill up, then a dropped append and a replacement while full.
        for (int j = 2; j < QUEUE_DEPTH; j++) begin
            add_cmd(CMD_ENQ, key_pool[j], $urandom);
        end
        add_cmd(CMD_ENQ, key_pool[QUEUE_DEPTH], $urandom);
        add_cmd(CMD_ENQ, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
        // Removal from the middle, the head and the tail.
        add_cmd(CMD_DEQ_KEY, key_pool[5], 32'h0);
        add_cmd(CMD_DEQ_HEAD, 32'h0, 32'h0);
        add_cmd(CMD_DEQ_KEY, key_pool[QUEUE_DEPTH - 1], 32'h0);

        // Random part in phases that lean toward filling, draining, or a mix.
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            phase = (n / 40) % 3;
            pick  = $urandom_range(99);
            if (phase == 0) begin
                op = (pick < 65) ? CMD_ENQ : (pick < 75) ? CMD_DEQ_HEAD :
                     (pick < 85) ? CMD_DEQ_KEY : CMD_QUERY;
            end else if (phase == 1) begin
                op = (pick < 20) ? CMD_ENQ : (pick < 55) ? CMD_DEQ_HEAD :
                     (pick < 85) ? CMD_DEQ_KEY : CMD_QUERY;
            end else begin
                op = (pick < 40) ? CMD_ENQ : (pick < 60) ? CMD_DEQ_HEAD :
                     (pick < 80) ? CMD_DEQ_KEY : CMD_QUERY;
            end
            add_cmd(op, pick_key(), $urandom);
        end
        total_cmds = cmd_backlog.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every command owes exactly one reply; a lost reply ends the run by the watchdog.
        while (replies_seen < total_cmds) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (replies_due.size() != 0) begin
            error_count++;
        end
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/ccq_pkg.sv
hdl/ccq_ram.sv
hdl/coalescing_command_queue.sv
verif/testbench.sv
